@@ src/lpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpu_pkg
// shared types, widths and rounding helpers for the point undistortion block
// ----------------------------------------------------------------------------
package lpu_pkg;

   localparam int FRAC           = 20;
   localparam int COEF_FRAC      = 16;
   localparam int TAN_FRAC       = 14;
   localparam int RADIAL_MIN     = 2;
   localparam int ITERATIONS_DEF = 6;
   localparam int PIX_W          = 20;
   localparam int NORM_W         = 24;
   localparam int QUO_W          = 24;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;

   // front divider: |point - center| * 2^20 + focal/2 over focal
   localparam int FN_NW = 42;
   localparam int FN_DW = 20;
   // iteration divider: |xd - dx| * 2^20 + |radial|/2 over |radial|
   localparam int IT_NW = 55;
   localparam int IT_DW = 47;

   localparam logic [NORM_W-1:0] NORM_LIM = NORM_W'(24'h800000);

   typedef enum logic [2:0] {
      REG_FOCAL_X,
      REG_FOCAL_Y,
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_RADIAL_K1,
      REG_RADIAL_K2,
      REG_RADIAL_K3,
      REG_TANGENTIAL
   } lpu_reg_type;

   typedef struct packed {
      logic                     pass;
      logic signed [PIX_W-1:0]  px;
      logic signed [PIX_W-1:0]  py;
      logic signed [NORM_W-1:0] xd;
      logic signed [NORM_W-1:0] yd;
      logic signed [NORM_W-1:0] xu;
      logic signed [NORM_W-1:0] yu;
   } lpu_item_type;

   typedef struct packed {
      logic signed [19:0] k1;
      logic signed [19:0] k2;
      logic signed [19:0] k3;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
   } lpu_cfg_type;

   // v * 2^-s, round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
      logic signed [63:0] half;
      logic signed [63:0] t;
      half = 64'sd1 <<< (s - 1);
      t = v + half - ((v < 64'sd0) ? 64'sd1 : 64'sd0);
      return t >>> s;
   endfunction

   function automatic logic q_fits(input logic [QUO_W-1:0] q, input logic neg,
                                   input logic ovf);
      return !ovf && (neg ? (q <= NORM_LIM) : (q < NORM_LIM));
   endfunction

   function automatic logic signed [NORM_W-1:0] q_apply(input logic [QUO_W-1:0] q,
                                                        input logic neg);
      return neg ? $signed(NORM_W'(~q + QUO_W'(1))) : $signed(NORM_W'(q));
   endfunction

endpackage

@@ src/lens_point_undistort.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_point_undistort
// brown-conrady point undistortion: normalize, iterate, map back to pixels
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_stall  | req_point_x, req_point_y
//   rsp     | out | rsp_valid / rsp_stall  | rsp_corrected_x/_y, rsp_corrected
//   csr     | in  | psel penable pwrite    | paddr, pwdata, prdata, pready
//
// one word accepted per cycle while the pipeline is not held, one result word per input word
// the front end and every correction pass each hold a pair of 25-stage dividers
// reset clears all valid bits and the configuration registers
// a stalled result holds the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module lens_point_undistort #(
   parameter int ITERATIONS = lpu_pkg::ITERATIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [lpu_pkg::PIX_W-1:0] req_point_x,
   input  logic signed [lpu_pkg::PIX_W-1:0] req_point_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [lpu_pkg::PIX_W-1:0] rsp_corrected_x,
   output logic signed [lpu_pkg::PIX_W-1:0] rsp_corrected_y,
   output logic                             rsp_corrected,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lpu_pkg::ADDR_W-1:0]       paddr,
   input  logic [lpu_pkg::DATA_W-1:0]       pwdata,
   output logic [lpu_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);
   import lpu_pkg::*;

   localparam int SW = $bits(lpu_item_type) + 1;

   logic [19:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [19:0] radial_k1_ff, radial_k2_ff, radial_k3_ff;
   logic [31:0] tangential_ff;
   lpu_cfg_type cfg;
   lpu_reg_type reg_sel;
   logic        pipe_en;

   // configuration
   assign reg_sel = lpu_reg_type'(paddr[4:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff    <= '0;
         focal_y_ff    <= '0;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         radial_k1_ff  <= '0;
         radial_k2_ff  <= '0;
         radial_k3_ff  <= '0;
         tangential_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_sel)
            REG_FOCAL_X:    focal_x_ff    <= pwdata[19:0];
            REG_FOCAL_Y:    focal_y_ff    <= pwdata[19:0];
            REG_CENTER_X:   center_x_ff   <= pwdata[19:0];
            REG_CENTER_Y:   center_y_ff   <= pwdata[19:0];
            REG_RADIAL_K1:  radial_k1_ff  <= pwdata[19:0];
            REG_RADIAL_K2:  radial_k2_ff  <= pwdata[19:0];
            REG_RADIAL_K3:  radial_k3_ff  <= pwdata[19:0];
            REG_TANGENTIAL: tangential_ff <= pwdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FOCAL_X:    prdata = DATA_W'(focal_x_ff);
         REG_FOCAL_Y:    prdata = DATA_W'(focal_y_ff);
         REG_CENTER_X:   prdata = DATA_W'(center_x_ff);
         REG_CENTER_Y:   prdata = DATA_W'(center_y_ff);
         REG_RADIAL_K1:  prdata = DATA_W'(radial_k1_ff);
         REG_RADIAL_K2:  prdata = DATA_W'(radial_k2_ff);
         REG_RADIAL_K3:  prdata = DATA_W'(radial_k3_ff);
         REG_TANGENTIAL: prdata = tangential_ff;
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      cfg.k1 = $signed(radial_k1_ff);
      cfg.k2 = $signed(radial_k2_ff);
      cfg.k3 = $signed(radial_k3_ff);
      cfg.p1 = $signed(tangential_ff[31:16]);
      cfg.p2 = $signed(tangential_ff[15:0]);
   end

   assign pipe_en   = !rsp_valid || !rsp_stall;
   assign req_stall = !pipe_en;

   // input stage
   logic               t0_valid_ff, t0_pass_ff;
   logic signed [19:0] t0_px_ff, t0_py_ff;
   logic signed [21:0] t0_nx_ff, t0_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         t0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t0_px_ff   <= req_point_x;
         t0_py_ff   <= req_point_y;
         t0_nx_ff   <= 22'(req_point_x) - $signed({2'b00, center_x_ff});
         t0_ny_ff   <= 22'(req_point_y) - $signed({2'b00, center_y_ff});
         t0_pass_ff <= (cfg == '0) || (focal_x_ff == '0) || (focal_y_ff == '0);
      end
   end

   // front divider operands
   logic             t1_valid_ff;
   logic [FN_NW-1:0] t1_numx_ff, t1_numy_ff;
   logic             t1_negx_ff, t1_negy_ff;
   lpu_item_type     t1_item_ff;
   logic [21:0]      nxm, nym;

   assign nxm = (t0_nx_ff < 22'sd0) ? 22'(-t0_nx_ff) : 22'(t0_nx_ff);
   assign nym = (t0_ny_ff < 22'sd0) ? 22'(-t0_ny_ff) : 22'(t0_ny_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         t1_valid_ff <= t0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1_numx_ff      <= (FN_NW'(nxm) << FRAC) + FN_NW'(focal_x_ff >> 1);
         t1_numy_ff      <= (FN_NW'(nym) << FRAC) + FN_NW'(focal_y_ff >> 1);
         t1_negx_ff      <= t0_nx_ff < 22'sd0;
         t1_negy_ff      <= t0_ny_ff < 22'sd0;
         t1_item_ff.pass <= t0_pass_ff;
         t1_item_ff.px   <= t0_px_ff;
         t1_item_ff.py   <= t0_py_ff;
         t1_item_ff.xd   <= '0;
         t1_item_ff.yd   <= '0;
         t1_item_ff.xu   <= '0;
         t1_item_ff.yu   <= '0;
      end
   end

   logic             fdx_valid;
   logic [QUO_W-1:0] fqx, fqy;
   logic             fovfx, fovfy;
   logic [SW-1:0]    fdx_side;
   logic [0:0]       fdy_side;

   lpu_div #(
      .NW(FN_NW), .DW(FN_DW), .QW(QUO_W), .SW(SW)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (t1_valid_ff),
      .num      (t1_numx_ff),
      .den      (focal_x_ff),
      .side     ({t1_item_ff, t1_negx_ff}),
      .out_valid(fdx_valid),
      .quo      (fqx),
      .out_ovf  (fovfx),
      .out_side (fdx_side)
   );

   lpu_div #(
      .NW(FN_NW), .DW(FN_DW), .QW(QUO_W), .SW(1)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (t1_valid_ff),
      .num      (t1_numy_ff),
      .den      (focal_y_ff),
      .side     (t1_negy_ff),
      .out_valid(),
      .quo      (fqy),
      .out_ovf  (fovfy),
      .out_side (fdy_side)
   );

   // normalized point
   lpu_item_type t2_in, t2_item_ff;
   lpu_item_type fd_item;
   logic         t2_valid_ff;

   always_comb begin
      fd_item = lpu_item_type'(fdx_side[SW-1:1]);
      t2_in = fd_item;
      t2_in.xd = q_apply(fqx, fdx_side[0]);
      t2_in.yd = q_apply(fqy, fdy_side[0]);
      t2_in.xu = t2_in.xd;
      t2_in.yu = t2_in.yd;
      t2_in.pass = fd_item.pass || !q_fits(fqx, fdx_side[0], fovfx) ||
                   !q_fits(fqy, fdy_side[0], fovfy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         t2_valid_ff <= fdx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t2_item_ff <= t2_in;
      end
   end

   // correction passes
   logic         chain_valid [ITERATIONS+1];
   lpu_item_type chain_item  [ITERATIONS+1];

   assign chain_valid[0] = t2_valid_ff;
   assign chain_item[0]  = t2_item_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      lpu_iter u_iter (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .in_valid (chain_valid[i]),
         .in_item  (chain_item[i]),
         .cfg      (cfg),
         .out_valid(chain_valid[i+1]),
         .out_item (chain_item[i+1])
      );
   end

   // back to pixels
   logic               f1_valid_ff, f2_valid_ff;
   lpu_item_type       f1_item_ff, f2_item_ff;
   logic signed [44:0] f1_px_ff, f1_py_ff;
   logic signed [25:0] f2_rx_ff, f2_ry_ff;
   logic               rsp_valid_ff, rsp_corrected_ff;
   logic signed [19:0] rsp_x_ff, rsp_y_ff;
   logic               pix_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         f1_valid_ff  <= chain_valid[ITERATIONS];
         f2_valid_ff  <= f1_valid_ff;
         rsp_valid_ff <= f2_valid_ff;
      end
   end

   assign pix_ok = (f2_rx_ff >= -26'sd524288) && (f2_rx_ff <= 26'sd524287) &&
                   (f2_ry_ff >= -26'sd524288) && (f2_ry_ff <= 26'sd524287);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         f1_item_ff <= chain_item[ITERATIONS];
         f1_px_ff   <= $signed({1'b0, focal_x_ff}) * chain_item[ITERATIONS].xu;
         f1_py_ff   <= $signed({1'b0, focal_y_ff}) * chain_item[ITERATIONS].yu;

         f2_item_ff <= f1_item_ff;
         f2_rx_ff   <= 26'(rnd_shr(64'(f1_px_ff), FRAC)) + $signed({6'b0, center_x_ff});
         f2_ry_ff   <= 26'(rnd_shr(64'(f1_py_ff), FRAC)) + $signed({6'b0, center_y_ff});

         if (f2_item_ff.pass || !pix_ok) begin
            rsp_x_ff         <= f2_item_ff.px;
            rsp_y_ff         <= f2_item_ff.py;
            rsp_corrected_ff <= 1'b0;
         end else begin
            rsp_x_ff         <= f2_rx_ff[19:0];
            rsp_y_ff         <= f2_ry_ff[19:0];
            rsp_corrected_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corrected_x = rsp_x_ff;
   assign rsp_corrected_y = rsp_y_ff;
   assign rsp_corrected   = rsp_corrected_ff;

   // checks
   a_freeze_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(t0_valid_ff) && $stable(t0_px_ff))
      else $error("input stage moved while pipeline held");

   a_front_advance: assert property (@(posedge clock) disable iff (reset)
      (pipe_en && t0_valid_ff) |=> t1_valid_ff)
      else $error("word lost between input stage and divider prep");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ src/lpu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpu_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module lpu_div #(
   parameter int NW = 42,
   parameter int DW = 20,
   parameter int QW = 24,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic          out_ovf,
   output logic [SW-1:0] out_side
);

   logic [QW:0]   vld_ff;
   logic [QW:0]   ovf_ff;
   logic [NW-1:0] rem_ff  [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= (num >> QW) >= NW'(den);
         side_ff[0] <= side;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      localparam int B = QW - k;
      logic          fit_in;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] q_in;

      always_comb begin
         fit_in = (rem_ff[k-1] >> B) >= NW'(den_ff[k-1]);
         rem_in = fit_in ? (rem_ff[k-1] - (NW'(den_ff[k-1]) << B)) : rem_ff[k-1];
         q_in = q_ff[k-1];
         q_in[B] = fit_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_ff[k-1];
            q_ff[k]    <= q_in;
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo       = q_ff[QW];
   assign out_ovf   = ovf_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

@@ src/lpu_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpu_iter
// one correction pass: radial factor, tangential offset, divide, range check
// ----------------------------------------------------------------------------
module lpu_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  lpu_pkg::lpu_item_type in_item,
   input  lpu_pkg::lpu_cfg_type  cfg,
   output logic                 out_valid,
   output lpu_pkg::lpu_item_type out_item
);
   import lpu_pkg::*;

   localparam int NST = 13;
   localparam int SW  = $bits(lpu_item_type) + 1;
   localparam logic signed [47:0] ONE_Q20 = 48'sd1 <<< FRAC;
   localparam logic signed [47:0] RAD_LIM = 48'(RADIAL_MIN);

   logic [NST-1:0] vld_ff;
   lpu_item_type   item_ff [NST];

   logic signed [47:0] x2p_ff, y2p_ff, xyp_ff;
   logic signed [27:0] x2_ff, y2_ff, xy2_ff;
   logic signed [28:0] r2_3_ff;
   logic signed [29:0] ax_ff, ay_ff;
   logic signed [27:0] xy3_ff;
   logic signed [57:0] r4p_ff;
   logic signed [48:0] k1r2_4_ff, k1r2_5_ff, k1r2_6_ff, k1r2_7_ff, k1r2_8_ff, k1r2_9_ff;
   logic signed [48:0] k1r2_10_ff;
   logic signed [43:0] pxy_ff, qxy_ff;
   logic signed [45:0] pax_ff, pay_ff;
   logic signed [28:0] r2_4_ff, r2_5_ff;
   logic signed [35:0] r4_ff;
   logic signed [46:0] dxs_ff, dys_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [53:0] r6a_ff;
   logic signed [40:0] r6b_ff;
   logic signed [44:0] k2a_ff;
   logic signed [31:0] k2b_ff;
   logic signed [62:0] r6p_ff;
   logic signed [54:0] k2r4_7_ff, k2r4_8_ff, k2r4_9_ff, k2r4_10_ff;
   logic signed [33:0] nx_7_ff, nx_8_ff, nx_9_ff, nx_10_ff, nx_11_ff, nx_12_ff;
   logic signed [33:0] ny_7_ff, ny_8_ff, ny_9_ff, ny_10_ff, ny_11_ff, ny_12_ff;
   logic signed [42:0] r6_ff;
   logic signed [44:0] k3a_ff;
   logic signed [38:0] k3b_ff;
   logic signed [62:0] k3r6_ff;
   logic signed [62:0] acc_ff;
   logic signed [47:0] radial_ff;
   logic [IT_NW-1:0]   numx_ff, numy_ff;
   logic [IT_DW-1:0]   den_ff;
   logic               negx_ff, negy_ff;
   lpu_item_type       item13_in;

   logic               dvx_valid;
   logic [QUO_W-1:0]   qx, qy;
   logic               ovfx, ovfy;
   logic [SW-1:0]      dvx_side;
   logic [0:0]         dvy_side;
   lpu_item_type       dv_item;
   logic               dv_negx;
   lpu_item_type       out_in;
   logic               out_valid_ff;
   lpu_item_type       out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= in_item;
         for (int i = 1; i < NST - 1; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
         item_ff[NST-1] <= item13_in;
      end
   end

   // squares, cross term, r2 and the tangential sums
   always_ff @(posedge clock) begin
      if (en) begin
         x2p_ff <= in_item.xu * in_item.xu;
         y2p_ff <= in_item.yu * in_item.yu;
         xyp_ff <= in_item.xu * in_item.yu;

         x2_ff  <= 28'(rnd_shr(64'(x2p_ff), FRAC));
         y2_ff  <= 28'(rnd_shr(64'(y2p_ff), FRAC));
         xy2_ff <= 28'(rnd_shr(64'(xyp_ff), FRAC));

         r2_3_ff <= 29'(x2_ff) + 29'(y2_ff);
         ax_ff   <= (30'(x2_ff) <<< 1) + 30'(x2_ff) + 30'(y2_ff);
         ay_ff   <= (30'(y2_ff) <<< 1) + 30'(y2_ff) + 30'(x2_ff);
         xy3_ff  <= xy2_ff;
      end
   end

   // r4, k1 term and tangential products
   always_ff @(posedge clock) begin
      if (en) begin
         r4p_ff    <= r2_3_ff * r2_3_ff;
         k1r2_4_ff <= cfg.k1 * r2_3_ff;
         pxy_ff    <= cfg.p1 * xy3_ff;
         qxy_ff    <= cfg.p2 * xy3_ff;
         pax_ff    <= cfg.p2 * ax_ff;
         pay_ff    <= cfg.p1 * ay_ff;
         r2_4_ff   <= r2_3_ff;

         r4_ff     <= 36'(rnd_shr(64'(r4p_ff), FRAC));
         dxs_ff    <= (47'(pxy_ff) <<< 1) + 47'(pax_ff);
         dys_ff    <= 47'(pay_ff) + (47'(qxy_ff) <<< 1);
         r2_5_ff   <= r2_4_ff;
         k1r2_5_ff <= k1r2_4_ff;
      end
   end

   // tangential offsets, r6 and k2 products in halves
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff     <= 33'(rnd_shr(64'(dxs_ff), TAN_FRAC));
         dy_ff     <= 33'(rnd_shr(64'(dys_ff), TAN_FRAC));
         r6a_ff    <= r2_5_ff * $signed({1'b0, r4_ff[23:0]});
         r6b_ff    <= r2_5_ff * $signed(r4_ff[35:24]);
         k2a_ff    <= cfg.k2 * $signed({1'b0, r4_ff[23:0]});
         k2b_ff    <= cfg.k2 * $signed(r4_ff[35:24]);
         k1r2_6_ff <= k1r2_5_ff;

         r6p_ff    <= (63'(r6b_ff) <<< 24) + 63'(r6a_ff);
         k2r4_7_ff <= (55'(k2b_ff) <<< 24) + 55'(k2a_ff);
         nx_7_ff   <= 34'(item_ff[5].xd) - 34'(dx_ff);
         ny_7_ff   <= 34'(item_ff[5].yd) - 34'(dy_ff);
         k1r2_7_ff <= k1r2_6_ff;
      end
   end

   // k3 term and sum of radial terms
   always_ff @(posedge clock) begin
      if (en) begin
         r6_ff      <= 43'(rnd_shr(64'(r6p_ff), FRAC));
         k2r4_8_ff  <= k2r4_7_ff;
         k1r2_8_ff  <= k1r2_7_ff;
         nx_8_ff    <= nx_7_ff;
         ny_8_ff    <= ny_7_ff;

         k3a_ff     <= cfg.k3 * $signed({1'b0, r6_ff[23:0]});
         k3b_ff     <= cfg.k3 * $signed(r6_ff[42:24]);
         k2r4_9_ff  <= k2r4_8_ff;
         k1r2_9_ff  <= k1r2_8_ff;
         nx_9_ff    <= nx_8_ff;
         ny_9_ff    <= ny_8_ff;

         k3r6_ff    <= (63'(k3b_ff) <<< 24) + 63'(k3a_ff);
         k2r4_10_ff <= k2r4_9_ff;
         k1r2_10_ff <= k1r2_9_ff;
         nx_10_ff   <= nx_9_ff;
         ny_10_ff   <= ny_9_ff;

         acc_ff     <= 63'(k1r2_10_ff) + 63'(k2r4_10_ff) + k3r6_ff;
         nx_11_ff   <= nx_10_ff;
         ny_11_ff   <= ny_10_ff;

         radial_ff  <= 48'(rnd_shr(64'(acc_ff), COEF_FRAC)) + ONE_Q20;
         nx_12_ff   <= nx_11_ff;
         ny_12_ff   <= ny_11_ff;
      end
   end

   // divider operands
   logic [IT_DW-1:0] radm;
   logic [33:0]      nxm, nym;

   always_comb begin
      radm = (radial_ff < 48'sd0) ? IT_DW'(-radial_ff) : IT_DW'(radial_ff);
      nxm  = (nx_12_ff < 34'sd0) ? 34'(-nx_12_ff) : 34'(nx_12_ff);
      nym  = (ny_12_ff < 34'sd0) ? 34'(-ny_12_ff) : 34'(ny_12_ff);
      item13_in = item_ff[NST-2];
      item13_in.pass = item_ff[NST-2].pass || ((radial_ff > -RAD_LIM) && (radial_ff < RAD_LIM));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= (IT_NW'(nxm) << FRAC) + IT_NW'(radm >> 1);
         numy_ff <= (IT_NW'(nym) << FRAC) + IT_NW'(radm >> 1);
         den_ff  <= radm;
         negx_ff <= (nx_12_ff < 34'sd0) ^ (radial_ff < 48'sd0);
         negy_ff <= (ny_12_ff < 34'sd0) ^ (radial_ff < 48'sd0);
      end
   end

   lpu_div #(
      .NW(IT_NW), .DW(IT_DW), .QW(QUO_W), .SW(SW)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vld_ff[NST-1]),
      .num      (numx_ff),
      .den      (den_ff),
      .side     ({item_ff[NST-1], negx_ff}),
      .out_valid(dvx_valid),
      .quo      (qx),
      .out_ovf  (ovfx),
      .out_side (dvx_side)
   );

   lpu_div #(
      .NW(IT_NW), .DW(IT_DW), .QW(QUO_W), .SW(1)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vld_ff[NST-1]),
      .num      (numy_ff),
      .den      (den_ff),
      .side     (negy_ff),
      .out_valid(),
      .quo      (qy),
      .out_ovf  (ovfy),
      .out_side (dvy_side)
   );

   always_comb begin
      dv_item = lpu_item_type'(dvx_side[SW-1:1]);
      dv_negx = dvx_side[0];
      out_in = dv_item;
      out_in.xu = q_apply(qx, dv_negx);
      out_in.yu = q_apply(qy, dvy_side[0]);
      out_in.pass = dv_item.pass || !q_fits(qx, dv_negx, ovfx) ||
                    !q_fits(qy, dvy_side[0], ovfy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dvx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lens_point_undistort
//
// points are fed through a valid/stall driver with random gaps. each accepted
// word is run through a bit-accurate fixed-point undistortion model in the
// bench, and the result words are compared in order, field by field. the
// lens settings are changed over several phases through the register port.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic signed [19:0] x;
      logic signed [19:0] y;
   } point_type;

   typedef struct {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic               c;
   } undist_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic signed [19:0] req_point_x = '0;
   logic signed [19:0] req_point_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [19:0] rsp_corrected_x;
   logic signed [19:0] rsp_corrected_y;
   logic        rsp_corrected;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [lpu_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   lens_point_undistort u_dut (.*);

   always #4 clock = ~clock;

   // lens settings as seen by the bench
   longint lens_fx, lens_fy, lens_cx, lens_cy, lens_k1, lens_k2, lens_k3;
   longint lens_p1, lens_p2;

   point_type  pending_pts[$];
   undist_type undist_q[$];
   int      err_count = 0;
   int      n_in = 0, n_out = 0, n_corr = 0, n_writes = 0;
   bit      quiet = 0;

   function automatic longint rnd_shift(longint v, int s);
      longint unsigned m;
      m = ((v < 0) ? -v : v) + (64'd1 << (s - 1));
      m = m >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint rnd_div(longint n, longint d);
      longint unsigned dm, m;
      if (d == 0) return 0;
      dm = (d < 0) ? -d : d;
      m = ((((n < 0) ? -n : n) << 20) + dm / 2) / dm;
      return ((n < 0) != (d < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic bit norm_fits(longint v);
      return v >= -(64'sd1 <<< 23) && v <= (64'sd1 <<< 23) - 1;
   endfunction

   function automatic undist_type expected_word(logic signed [19:0] px,
                                                logic signed [19:0] py);
      undist_type r;
      longint xd, yd, xu, yu, x2, y2, xy, r2, r4, r6, rad, dx, dy, rx, ry;
      r.x = px;
      r.y = py;
      r.c = 1'b0;
      if (lens_k1 == 0 && lens_k2 == 0 && lens_k3 == 0 && lens_p1 == 0 && lens_p2 == 0)
         return r;
      if (lens_fx == 0 || lens_fy == 0) return r;
      xd = rnd_div(longint'(px) - lens_cx, lens_fx);
      yd = rnd_div(longint'(py) - lens_cy, lens_fy);
      if (!norm_fits(xd) || !norm_fits(yd)) return r;
      xu = xd;
      yu = yd;
      for (int i = 0; i < lpu_pkg::ITERATIONS_DEF; i++) begin
         x2 = rnd_shift(xu * xu, 20);
         y2 = rnd_shift(yu * yu, 20);
         xy = rnd_shift(xu * yu, 20);
         r2 = x2 + y2;
         r4 = rnd_shift(r2 * r2, 20);
         r6 = rnd_shift(r4 * r2, 20);
         rad = (64'sd1 <<< 20) + rnd_shift(lens_k1 * r2 + lens_k2 * r4 + lens_k3 * r6, 16);
         if (rad > -2 && rad < 2) return r;
         dx = rnd_shift(2 * lens_p1 * xy + lens_p2 * (r2 + 2 * x2), 14);
         dy = rnd_shift(lens_p1 * (r2 + 2 * y2) + 2 * lens_p2 * xy, 14);
         xu = rnd_div(xd - dx, rad);
         yu = rnd_div(yd - dy, rad);
         if (!norm_fits(xu) || !norm_fits(yu)) return r;
      end
      rx = rnd_shift(lens_fx * xu, 20) + lens_cx;
      ry = rnd_shift(lens_fy * yu, 20) + lens_cy;
      if (rx < -524288 || rx > 524287 || ry < -524288 || ry > 524287) return r;
      r.x = rx[19:0];
      r.y = ry[19:0];
      r.c = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   int drv_gap = 0;
   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            undist_q.push_back(expected_word(req_point_x, req_point_y));
            n_in++;
         end
         if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (pending_pts.size() > 0) begin
            p = pending_pts.pop_front();
            req_point_x <= p.x;
            req_point_y <= p.y;
            req_valid <= 1'b1;
            drv_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and result stall
   int  stall_left = 0;
   bit  held = 0;
   always @(posedge clock) begin
      undist_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_out++;
         if (undist_q.size() == 0) begin
            $error("result word with nothing expected");
            err_count++;
         end else begin
            e = undist_q.pop_front();
            if (rsp_corrected) n_corr++;
            if (rsp_corrected_x !== e.x) begin
               $error("corrected_x expected %0d got %0d", e.x, rsp_corrected_x);
               err_count++;
            end
            if (rsp_corrected_y !== e.y) begin
               $error("corrected_y expected %0d got %0d", e.y, rsp_corrected_y);
               err_count++;
            end
            if (rsp_corrected !== e.c) begin
               $error("corrected expected %0d got %0d", e.c, rsp_corrected);
               err_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!held && n_out >= 150) begin
         held = 1;
         stall_left = 600;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 20000) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(lpu_pkg::lpu_reg_type r, logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      n_writes++;
      case (r)
         lpu_pkg::REG_FOCAL_X:    lens_fx = longint'(v[19:0]);
         lpu_pkg::REG_FOCAL_Y:    lens_fy = longint'(v[19:0]);
         lpu_pkg::REG_CENTER_X:   lens_cx = longint'(v[19:0]);
         lpu_pkg::REG_CENTER_Y:   lens_cy = longint'(v[19:0]);
         lpu_pkg::REG_RADIAL_K1:  lens_k1 = longint'($signed(v[19:0]));
         lpu_pkg::REG_RADIAL_K2:  lens_k2 = longint'($signed(v[19:0]));
         lpu_pkg::REG_RADIAL_K3:  lens_k3 = longint'($signed(v[19:0]));
         lpu_pkg::REG_TANGENTIAL: begin
            lens_p1 = longint'($signed(v[31:16]));
            lens_p2 = longint'($signed(v[15:0]));
         end
         default: ;
      endcase
   endtask

   task automatic set_lens(int fx, int fy, int cx, int cy, int k1, int k2, int k3,
                           logic [31:0] tan);
      csr_write(lpu_pkg::REG_FOCAL_X, fx);
      csr_write(lpu_pkg::REG_FOCAL_Y, fy);
      csr_write(lpu_pkg::REG_CENTER_X, cx);
      csr_write(lpu_pkg::REG_CENTER_Y, cy);
      csr_write(lpu_pkg::REG_RADIAL_K1, k1);
      csr_write(lpu_pkg::REG_RADIAL_K2, k2);
      csr_write(lpu_pkg::REG_RADIAL_K3, k3);
      csr_write(lpu_pkg::REG_TANGENTIAL, tan);
   endtask

   task automatic add_point(int x, int y);
      point_type p;
      p.x = x;
      p.y = y;
      pending_pts.push_back(p);
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_pts.size() > 0 || req_valid || undist_q.size() > 0)
         @(negedge clock);
   endtask

   task automatic add_random(int n, bit near);
      for (int i = 0; i < n; i++) begin
         if (near)
            add_point(lens_cx + $urandom_range(0, 2 * lens_fx) - lens_fx,
                      lens_cy + $urandom_range(0, 2 * lens_fy) - lens_fy);
         else
            add_point($urandom, $urandom);
      end
   endtask

   initial begin
      lens_fx = 0; lens_fy = 0; lens_cx = 0; lens_cy = 0;
      lens_k1 = 0; lens_k2 = 0; lens_k3 = 0; lens_p1 = 0; lens_p2 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // after reset everything passes through
      add_point(524287, -524288);
      add_point(-524288, 524287);
      add_point(0, 0);
      add_point(-1, 1);
      drain();

      // typical lens, with field extremes
      set_lens(8000, 8100, 5120, 3840, -6000, 1200, -300, {16'sd150, -16'sd90});
      add_point(524287, 524287);
      add_point(-524288, -524288);
      add_point(5120, 3840);
      add_point(0, 0);
      add_point(10240, 7680);
      add_point(13120, 3840);
      drain();

      // radial factor collapses to zero at unit radius
      set_lens(1000, 1000, 0, 0, -65536, 0, 0, 32'h0);
      add_point(1000, 0);
      add_point(0, -1000);
      add_point(500, 500);
      // no distortion with focal set
      drain();
      set_lens(8000, 8000, 100, 100, 0, 0, 0, 32'h0);
      add_point(4000, 4000);
      drain();
      // one focal length zero
      csr_write(lpu_pkg::REG_RADIAL_K1, 5000);
      csr_write(lpu_pkg::REG_FOCAL_Y, 0);
      add_point(4000, 4000);
      drain();
      // tiny focal: normalized overflow
      set_lens(1, 1, 0, 0, 1000, 0, 0, 32'h0);
      add_point(100, 100);
      add_point(8, -8);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         quiet = (ph == 2);
         set_lens($urandom_range(2000, 20000), $urandom_range(2000, 20000),
                  $urandom_range(0, 12000), $urandom_range(0, 12000),
                  int'($urandom_range(0, 40000)) - 20000,
                  int'($urandom_range(0, 10000)) - 5000,
                  int'($urandom_range(0, 2000)) - 1000,
                  {16'(int'($urandom_range(0, 800)) - 400),
                   16'(int'($urandom_range(0, 800)) - 400)});
         add_random(220, 1);
         add_random(30, 0);
         drain();
      end
      quiet = 0;

      // coefficient and focal extremes
      set_lens(1048575, 1048575, 1048575, 1048575, 327680, 327680, 327680, 32'hFFFFFFFF);
      add_random(80, 0);
      drain();
      set_lens(1048575, 1, 0, 524287, -327680, -327680, -327680, 32'h80007FFF);
      add_random(80, 0);
      drain();
      set_lens(300, 300, 0, 0, 327680, -327680, 0, 32'h7FFF8000);
      add_random(40, 1);
      add_random(40, 0);
      drain();
      set_lens(4096, 4096, 2048, 2048, 0, 0, 0, 32'h00010000);
      add_random(80, 1);
      drain();
      set_lens(6000, 6000, 4000, 4000, 0, 0, 20000, 32'h0);
      add_random(80, 1);
      drain();

      repeat (300) @(posedge clock);
      $display("run covered %0d points over %0d register writes", n_in, n_writes);
      $display("%0d results corrected, %0d passed through", n_corr, n_out - n_corr);
      if (err_count == 0 && undist_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ lens_point_undistort.f @@
src/lpu_pkg.sv
src/lpu_div.sv
src/lpu_iter.sv
src/lens_point_undistort.sv
tb/tb.sv
